// ----- hw/rtl/dqr_pkg.sv -----
package dqr_pkg;

    // Payload widths fixed by the item format
    localparam int unsigned MODE_W = 2;
    localparam int unsigned DATA_W = 32;

    // Default number of slots in the ring store
    localparam int unsigned DEF_DEPTH = 16;

    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic signed [DATA_W-1:0] t_data;

    // Operation codes carried in the mode field
    localparam t_mode MODE_INS_HEAD = 2'd0;
    localparam t_mode MODE_INS_TAIL = 2'd1;
    localparam t_mode MODE_REM_HEAD = 2'd2;
    localparam t_mode MODE_REVERSE  = 2'd3;

endpackage

// ----- hw/rtl/dqr_if.sv -----
// Request channel: one operation per request
interface dqr_req_if;
    logic            valid;
    logic            ready;
    dqr_pkg::t_mode  mode;
    dqr_pkg::t_data  data_in;

    modport src (output valid, output mode, output data_in, input ready);
    modport snk (input valid, input mode, input data_in, output ready);
endinterface

// Response channel: one result per request
interface dqr_rsp_if #(
    parameter int unsigned DEPTH = dqr_pkg::DEF_DEPTH
);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic             valid;
    logic             ready;
    logic             ok;
    dqr_pkg::t_data   removed_value;
    logic [CNT_W-1:0] count;

    modport src (output valid, output ok, output removed_value, output count, input ready);
    modport snk (input valid, input ok, input removed_value, input count, output ready);
endinterface

// ----- hw/rtl/double_ended_queue_with_reverse.sv -----
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    mode[1:0], data_in[31:0] signed
// o_rsp     out  valid/ready    ok, removed_value[31:0] signed, count
//
// Insert, reverse and a failed remove load the output register at the
// accepting edge. A successful remove goes through S_READ while the
// registered slot memory read completes, then loads the output register.
// Synchronous active-low reset clears pointers, count, orientation and the
// result valid; slot contents are not cleared and need no clearing pass.
// A request is taken only when the result register is empty or drained in
// the same cycle, so a stalled result holds off the input until it is taken.
module double_ended_queue_with_reverse #(
    parameter int unsigned DEPTH = dqr_pkg::DEF_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dqr_req_if.snk  i_req,
    dqr_rsp_if.src  o_rsp
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    dqr_pkg::t_data  wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    dqr_pkg::t_data  rd_data;

    // Pointer, count and orientation control with the result register
    dqr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // Ring slot store
    dqr_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ----- hw/rtl/dqr_ram.sv -----
module dqr_ram #(
    parameter int unsigned DEPTH = dqr_pkg::DEF_DEPTH,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  dqr_pkg::t_data  i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output dqr_pkg::t_data  o_rd_data
);

    dqr_pkg::t_data r_mem [DEPTH];
    dqr_pkg::t_data r_rd_data;

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/dqr_ctrl.sv -----
module dqr_ctrl #(
    parameter int unsigned DEPTH = dqr_pkg::DEF_DEPTH,
    localparam int unsigned AW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dqr_req_if.snk          i_req,
    dqr_rsp_if.src          o_rsp,
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output dqr_pkg::t_data  o_wr_data,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  dqr_pkg::t_data  i_rd_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic           r_state, n_state;
    logic [AW-1:0]  r_front, n_front;
    logic [AW-1:0]  r_back, n_back;
    logic [CW-1:0]  r_count, n_count;
    logic           r_rev, n_rev;

    logic           r_out_valid, n_out_valid;
    logic           r_out_ok, n_out_ok;
    dqr_pkg::t_data r_out_data, n_out_data;
    logic [CW-1:0]  r_out_count, n_out_count;

    logic           acc;
    logic           is_ins;
    logic           at_front;
    logic           full;
    logic           empty;
    logic [AW-1:0]  front_prev, front_next, back_prev, back_next;

    // Ring pointer neighbors
    assign front_prev = (r_front == '0) ? LAST_SLOT : r_front - AW'(1);
    assign front_next = (r_front == LAST_SLOT) ? '0 : r_front + AW'(1);
    assign back_prev  = (r_back == '0) ? LAST_SLOT : r_back - AW'(1);
    assign back_next  = (r_back == LAST_SLOT) ? '0 : r_back + AW'(1);

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    // Take a request only when idle and the result slot is empty or frees up this cycle
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign acc         = i_req.valid && i_req.ready;

    assign is_ins   = (i_req.mode == dqr_pkg::MODE_INS_HEAD) ||
                      (i_req.mode == dqr_pkg::MODE_INS_TAIL);
    assign at_front = ((i_req.mode == dqr_pkg::MODE_INS_HEAD) == !r_rev);

    assign o_wr_data = i_req.data_in;

    // Decode the request, update pointers and issue the slot access
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_rev       = r_rev;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_data  = r_out_data;
        n_out_count = r_out_count;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_back;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_front;

        // Drop the result once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_out_ok    = 1'b1;
                    n_out_data  = '0;
                    n_out_valid = 1'b1;
                    if (is_ins) begin
                        if (full) begin
                            n_out_ok = 1'b0;
                        end else begin
                            o_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                            if (at_front) begin
                                n_front   = front_prev;
                                o_wr_addr = front_prev;
                            end else begin
                                o_wr_addr = r_back;
                                n_back    = back_next;
                            end
                        end
                        n_out_count = n_count;
                    end else if (i_req.mode == dqr_pkg::MODE_REM_HEAD) begin
                        if (empty) begin
                            n_out_ok    = 1'b0;
                            n_out_count = r_count;
                        end else begin
                            // Slot data arrives next cycle; hold the result until then
                            o_rd_en     = 1'b1;
                            n_count     = r_count - CW'(1);
                            n_out_valid = 1'b0;
                            n_state     = S_READ;
                            if (!r_rev) begin
                                o_rd_addr = r_front;
                                n_front   = front_next;
                            end else begin
                                o_rd_addr = back_prev;
                                n_back    = back_prev;
                            end
                        end
                    end else begin
                        n_rev       = !r_rev;
                        n_out_count = r_count;
                    end
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_ok    = 1'b1;
                n_out_data  = i_rd_data;
                n_out_count = r_count;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_ok    <= n_out_ok;
        r_out_data  <= n_out_data;
        r_out_count <= n_out_count;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.ok            = r_out_ok;
    assign o_rsp.removed_value = r_out_data;
    assign o_rsp.count         = r_out_count;

endmodule
